// ===== rtl/emr_pkg.sv =====
// emr_pkg: shared types, codes and constants of the extent map read translator
// used by every module in rtl/; depends on nothing

package emr_pkg;

	// table and request limits
	localparam int unsigned MAX_EXTENTS_DEF   = 64;
	localparam int unsigned MAX_REQUEST_BYTES = 16384;
	localparam int unsigned CMD_DEPTH         = 4;
	localparam int unsigned CMD_PTR_W         = $clog2(CMD_DEPTH);

	// block size limits, log2 of bytes
	localparam logic [4:0] BS_MIN = 5'd9;
	localparam logic [4:0] BS_MAX = 5'd16;

	// register indexes on the configuration port
	localparam logic [2:0] CFG_BLOCK_SIZE_LOG2   = 3'd0;
	localparam logic [2:0] CFG_GROUP_BLOCKS_LOG2 = 3'd1;
	localparam logic [2:0] CFG_GROUP_BLOCKS      = 3'd2;
	localparam logic [2:0] CFG_FILE_LENGTH       = 3'd3;
	localparam logic [2:0] CFG_EXTENT_COUNT      = 3'd4;

	// register reset values
	localparam logic [4:0]  RST_BLOCK_SIZE_LOG2   = 5'd12;
	localparam logic [4:0]  RST_GROUP_BLOCKS_LOG2 = 5'd20;
	localparam logic [30:0] RST_GROUP_BLOCKS      = 31'd1048576;

	// item actions
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_MAPPED = 2'd1;
	localparam logic [1:0] KIND_HOLE   = 2'd2;

	// queued command codes
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_EMPTY = 2'd1;
	localparam logic [1:0] CMD_CHUNK = 2'd2;

	typedef struct packed {
		logic        action;
		logic [5:0]  entry_index;
		logic [53:0] logical_start;
		logic [51:0] physical_start;
		logic [20:0] extent_blocks;
		logic [62:0] position;
		logic [14:0] byte_count;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [62:0] device_address;
		logic [16:0] chunk_length;
		logic [14:0] buffer_offset;
		logic        last;
	} rsp_t;

	// live configuration, block size already saturated
	typedef struct packed {
		logic [4:0]  block_size_log2;
		logic [4:0]  group_blocks_log2;
		logic [30:0] group_blocks;
		logic [62:0] file_length;
		logic [6:0]  extent_count;
	} cfg_t;

	// one extent table entry
	typedef struct packed {
		logic [53:0] logical_start;
		logic [51:0] physical_start;
		logic [20:0] extent_blocks;
	} entry_t;

	// command from front to back
	typedef struct packed {
		logic [1:0]  op;
		logic [5:0]  entry_index;
		entry_t      entry;
		logic [53:0] lblock;
		logic [15:0] inblk;
		logic [16:0] chunk_len;
		logic [16:0] buf_off;
		logic        last;
	} cmd_t;

endpackage

// ===== rtl/emr_fifo.sv =====
// emr_fifo: short command queue between the front and the back
// depends on emr_pkg for cmd_t and the depth

module emr_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  emr_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output emr_pkg::cmd_t head
);
	import emr_pkg::*;

	cmd_t               slot_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_PTR_W:0]   cnt_q;

	assign full  = (cnt_q == (CMD_PTR_W+1)'(CMD_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (CMD_PTR_W+1)'(push && !full) - (CMD_PTR_W+1)'(pop && !empty);
		end
	end

endmodule

// ===== rtl/emr_front.sv =====
// emr_front: accepts items, clips read requests and splits them into block chunks
// depends on emr_pkg; feeds commands into emr_fifo

module emr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  emr_pkg::cfg_t cfg,
	input  logic          req_valid,
	output logic          req_stall,
	input  emr_pkg::req_t req,
	output logic          push,
	output emr_pkg::cmd_t push_cmd,
	input  logic          full
);
	import emr_pkg::*;

	localparam logic [1:0] F_IDLE  = 2'd0;
	localparam logic [1:0] F_CLS   = 2'd1;
	localparam logic [1:0] F_SPLIT = 2'd2;

	logic [1:0]  st_q;
	req_t        item_q;
	logic [62:0] at_q;
	logic [16:0] rem_q;
	logic [16:0] done_q;

	logic [16:0] want;
	logic [62:0] avail;
	logic        nothing;
	logic [16:0] want_eff;
	logic [16:0] blk_bytes;
	logic [15:0] inblk;
	logic [16:0] room;
	logic [16:0] chunk;
	logic [62:0] lb_full;

	assign req_stall = (st_q != F_IDLE);

	// request clipping
	always_comb begin
		want     = (32'(item_q.byte_count) > MAX_REQUEST_BYTES) ?
			17'(MAX_REQUEST_BYTES) : 17'(item_q.byte_count);
		nothing  = (want == '0) || (item_q.position >= cfg.file_length);
		avail    = cfg.file_length - item_q.position;
		want_eff = (avail < 63'(want)) ? avail[16:0] : want;
	end

	// chunk at the current position
	always_comb begin
		blk_bytes = 17'(1) << cfg.block_size_log2;
		inblk     = at_q[15:0] & (blk_bytes[15:0] - 16'd1);
		room      = blk_bytes - 17'(inblk);
		chunk     = (room < rem_q) ? room : rem_q;
		lb_full   = at_q >> cfg.block_size_log2;
	end

	// command to the queue
	always_comb begin
		push     = 1'b0;
		push_cmd = '0;
		unique case (st_q)
			F_CLS: begin
				push = !full && (item_q.action == ACT_LOAD || nothing);
				if (item_q.action == ACT_LOAD) begin
					push_cmd.op                   = CMD_LOAD;
					push_cmd.entry_index          = item_q.entry_index;
					push_cmd.entry.logical_start  = item_q.logical_start;
					push_cmd.entry.physical_start = item_q.physical_start;
					push_cmd.entry.extent_blocks  = item_q.extent_blocks;
				end else begin
					push_cmd.op = CMD_EMPTY;
				end
			end
			F_SPLIT: begin
				push               = !full;
				push_cmd.op        = CMD_CHUNK;
				push_cmd.lblock    = lb_full[53:0];
				push_cmd.inblk     = inblk;
				push_cmd.chunk_len = chunk;
				push_cmd.buf_off   = done_q;
				push_cmd.last      = (chunk == rem_q);
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// item register
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_q <= req;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= F_IDLE;
			at_q   <= '0;
			rem_q  <= '0;
			done_q <= '0;
		end else begin
			unique case (st_q)
				F_IDLE: begin
					if (req_valid) begin
						st_q <= F_CLS;
					end
				end
				F_CLS: begin
					if (item_q.action == ACT_READ && !nothing) begin
						at_q   <= item_q.position;
						rem_q  <= want_eff;
						done_q <= '0;
						st_q   <= F_SPLIT;
					end else if (!full) begin
						st_q <= F_IDLE;
					end
				end
				F_SPLIT: begin
					if (!full) begin
						at_q   <= at_q + 63'(chunk);
						rem_q  <= rem_q - chunk;
						done_q <= done_q + chunk;
						if (chunk == rem_q) begin
							st_q <= F_IDLE;
						end
					end
				end
				default: begin
					st_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/emr_back.sv =====
// emr_back: holds the extent table, scans it per chunk and forms the device address
// depends on emr_pkg; takes commands from emr_fifo and drives the result register

module emr_back #(
	parameter int unsigned MAX_EXTENTS = emr_pkg::MAX_EXTENTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  emr_pkg::cfg_t cfg,
	input  logic          q_empty,
	input  emr_pkg::cmd_t q_cmd,
	output logic          q_pop,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output emr_pkg::rsp_t rsp
);
	import emr_pkg::*;

	localparam int unsigned IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_EXTENTS + 1);

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_SCAN = 3'd1;
	localparam logic [2:0] B_PB   = 3'd2;
	localparam logic [2:0] B_MUL1 = 3'd3;
	localparam logic [2:0] B_MUL2 = 3'd4;
	localparam logic [2:0] B_SUM  = 3'd5;
	localparam logic [2:0] B_ADDR = 3'd6;
	localparam logic [2:0] B_EMIT = 3'd7;

	entry_t mem [MAX_EXTENTS];
	entry_t rd_q;

	logic [2:0]       st_q;
	cmd_t             cur_q;
	logic [CNT_W-1:0] idx_q;
	logic             rd_vld_s1;
	logic [1:0]       kind_q;
	logic [62:0]      addr_q;
	logic [20:0]      diff_q;
	logic [51:0]      phys_q;
	logic [52:0]      grp_q;
	logic [30:0]      rel_q;
	logic [57:0]      plo_q;
	logic [26:0]      phi_q;
	logic [53:0]      sum_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic [CNT_W-1:0] n_cnt;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	logic [31:0]      wr_idx;
	logic             mem_we;
	logic [53:0]      diff;
	logic             hit;
	logic [52:0]      pb;
	logic [52:0]      gmask;
	logic [56:0]      phi_full;
	logic [63:0]      shifted;
	logic [63:0]      addr_full;
	logic             slot_free;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign slot_free = !rsp_valid_q || !rsp_stall;

	// entries in use
	assign n_cnt = (32'(cfg.extent_count) > MAX_EXTENTS) ?
		CNT_W'(MAX_EXTENTS) : CNT_W'(cfg.extent_count);

	// table port control
	assign q_pop   = (st_q == B_IDLE) && !q_empty;
	assign wr_idx  = 32'(q_cmd.entry_index);
	assign wr_addr = wr_idx[IDX_W-1:0];
	assign mem_we  = q_pop && (q_cmd.op == CMD_LOAD) && (wr_idx < MAX_EXTENTS);
	assign rd_addr = idx_q[IDX_W-1:0];

	// extent table, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= q_cmd.entry;
		end
		rd_q <= mem[rd_addr];
	end

	// match test on the entry just read
	always_comb begin
		diff = cur_q.lblock - rd_q.logical_start;
		hit  = (cur_q.lblock >= rd_q.logical_start) && (diff[53:21] == '0) &&
			(diff[20:0] < rd_q.extent_blocks);
	end

	// address arithmetic pieces
	always_comb begin
		pb        = 53'(phys_q) + 53'(diff_q);
		gmask     = (53'(1) << cfg.group_blocks_log2) - 53'd1;
		phi_full  = 57'(grp_q[52:27]) * 57'(cfg.group_blocks);
		shifted   = 64'(sum_q) << cfg.block_size_log2;
		addr_full = shifted + 64'(cur_q.inblk);
	end

	// chunk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= B_IDLE;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			kind_q    <= KIND_NONE;
			addr_q    <= '0;
		end else begin
			unique case (st_q)
				B_IDLE: begin
					rd_vld_s1 <= 1'b0;
					idx_q     <= '0;
					if (!q_empty) begin
						if (q_cmd.op == CMD_EMPTY) begin
							kind_q <= KIND_NONE;
							addr_q <= '0;
							st_q   <= B_EMIT;
						end else if (q_cmd.op == CMD_CHUNK) begin
							st_q <= B_SCAN;
						end
					end
				end
				B_SCAN: begin
					if (rd_vld_s1 && hit) begin
						rd_vld_s1 <= 1'b0;
						st_q      <= B_PB;
					end else if (!rd_vld_s1 && idx_q >= n_cnt) begin
						kind_q <= KIND_HOLE;
						addr_q <= '0;
						st_q   <= B_EMIT;
					end else begin
						rd_vld_s1 <= (idx_q < n_cnt);
						if (idx_q < n_cnt) begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				B_PB: begin
					st_q <= B_MUL1;
				end
				B_MUL1: begin
					st_q <= B_MUL2;
				end
				B_MUL2: begin
					st_q <= B_SUM;
				end
				B_SUM: begin
					st_q <= B_ADDR;
				end
				B_ADDR: begin
					kind_q <= KIND_MAPPED;
					addr_q <= addr_full[62:0];
					st_q   <= B_EMIT;
				end
				B_EMIT: begin
					if (slot_free) begin
						st_q <= B_IDLE;
					end
				end
				default: begin
					st_q <= B_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_cmd;
		end
		if (st_q == B_SCAN && rd_vld_s1 && hit) begin
			diff_q <= diff[20:0];
			phys_q <= rd_q.physical_start;
		end
		if (st_q == B_PB) begin
			grp_q <= pb >> cfg.group_blocks_log2;
			rel_q <= 31'(pb & gmask);
		end
		if (st_q == B_MUL1) begin
			plo_q <= 58'(grp_q[26:0]) * 58'(cfg.group_blocks);
		end
		if (st_q == B_MUL2) begin
			phi_q <= phi_full[26:0];
		end
		if (st_q == B_SUM) begin
			sum_q <= plo_q[53:0] + {phi_q, 27'd0} + 54'(rel_q);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (st_q == B_EMIT && slot_free) begin
				rsp_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == B_EMIT && slot_free) begin
			rsp_q.kind           <= kind_q;
			rsp_q.device_address <= addr_q;
			if (kind_q == KIND_NONE) begin
				rsp_q.chunk_length  <= '0;
				rsp_q.buffer_offset <= '0;
				rsp_q.last          <= 1'b1;
			end else begin
				rsp_q.chunk_length  <= cur_q.chunk_len;
				rsp_q.buffer_offset <= cur_q.buf_off[14:0];
				rsp_q.last          <= cur_q.last;
			end
		end
	end

	// scan never runs past the entries in use
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_SCAN) |-> (idx_q <= n_cnt))
		else $error("scan index beyond extent count");

	// only mapped chunks carry an address
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.kind != KIND_MAPPED) |-> (rsp_q.device_address == '0))
		else $error("address on unmapped result");

	// empty result is a single final item
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.kind == KIND_NONE) |-> (rsp_q.last && rsp_q.chunk_length == '0))
		else $error("empty result not final");

	// a result leaves the sequencer as soon as the slot frees
	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_EMIT && slot_free) |=> (st_q == B_IDLE))
		else $error("sequencer stuck after transfer to result register");

endmodule

// ===== rtl/extent_map_read_translator_core.sv =====
// extent_map_read_translator_core: top level, configuration registers and wiring
// depends on emr_pkg, emr_front, emr_fifo and emr_back
//
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | emr_pkg::req_t
// rsp     | out       | rsp_valid/rsp_stall  | emr_pkg::rsp_t
// cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// a load passes F_IDLE and F_CLS in the front; a read passes both, then splits one chunk per
// cycle in F_SPLIT while the queue is not full; each chunk in the back scans the n entries in use,
//   one entry per cycle from the extent table memory, then runs the split multiply
// the front, the 4-deep command queue and the back stall independently
// reset returns control and configuration to their reset values; the extent table is not cleared

module extent_map_read_translator_core #(
	parameter int unsigned MAX_EXTENTS = emr_pkg::MAX_EXTENTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  emr_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output emr_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [62:0]   cfg_data
);
	import emr_pkg::*;

	logic [4:0]  bs_q;
	logic [4:0]  gl_q;
	logic [30:0] gb_q;
	logic [62:0] flen_q;
	logic [6:0]  ecnt_q;
	cfg_t        cfg;

	logic push;
	cmd_t push_cmd;
	logic full;
	logic pop;
	logic empty;
	cmd_t head;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q   <= RST_BLOCK_SIZE_LOG2;
			gl_q   <= RST_GROUP_BLOCKS_LOG2;
			gb_q   <= RST_GROUP_BLOCKS;
			flen_q <= '0;
			ecnt_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BLOCK_SIZE_LOG2:   bs_q   <= cfg_data[4:0];
				CFG_GROUP_BLOCKS_LOG2: gl_q   <= cfg_data[4:0];
				CFG_GROUP_BLOCKS:      gb_q   <= cfg_data[30:0];
				CFG_FILE_LENGTH:       flen_q <= cfg_data;
				CFG_EXTENT_COUNT:      ecnt_q <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	// live configuration, block size saturated
	always_comb begin
		cfg.block_size_log2   = (bs_q < BS_MIN) ? BS_MIN : ((bs_q > BS_MAX) ? BS_MAX : bs_q);
		cfg.group_blocks_log2 = gl_q;
		cfg.group_blocks      = gb_q;
		cfg.file_length       = flen_q;
		cfg.extent_count      = ecnt_q;
	end

	emr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full)
	);

	emr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	emr_back #(
		.MAX_EXTENTS (MAX_EXTENTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_empty   (empty),
		.q_cmd     (head),
		.q_pop     (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
